[rtl/core/lph_pkg.sv]
// Shared types and constants for the linear probing hash table.
// Holds the request and result beats, controller states and the
// command and status bundles. No dependencies.
`default_nettype none

package lph_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  // A power-of-two table takes the home slot straight from the low key bits.
  localparam bit TABLE_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // Reciprocal of the table size scaled by 2^32. Any other table size gets
  // its home slot from one multiply by this and a single correction.
  localparam logic [31:0] HOME_RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);

  localparam logic [1:0] MODE_PUT = 2'd0;
  localparam logic [1:0] MODE_GET = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] prev_value;
    logic        found;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_SCAN,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic home_step;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic home_last;
    logic hit;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/linear_probe_hash_table.sv]
// Top level of the linear probing hash table: 32-bit keys and values.
// Instantiates lph_ctrl and lph_datapath; types come from lph_pkg.
//
//   Channel   Handshake        Payload            Beat taken when
//   request   start / busy     lph_pkg::req_t     start high and busy low
//   result    done (strobe)    lph_pkg::rsp_t     done high, one cycle only
//
// After reset the block sweeps both memories to zero, one slot per cycle,
// so busy stays high until the sweep has cleared every slot.
// A request then probes from the home slot to the matching key: the
// probe loop reads one slot per cycle through the single memory port,
// pipelined with the compare. A miss (and a put of a new key) scans the
// whole table. Rejected requests and the unused mode skip the probe and
// go straight to the update step. When the table size is not a power of
// two, a reciprocal multiply with one correction step finds the home
// slot before the probe starts.
// The receiver cannot stall: the result is shown for exactly one cycle with
// done high, in the same cycle that busy falls, so a new request may be
// taken right away.
`default_nettype none

module linear_probe_hash_table (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire lph_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output lph_pkg::rsp_t      result
);
  import lph_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences clear, home slot, probe and update phases.
  lph_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the memories and the request and probe registers.
  lph_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .done    (done)
  );

endmodule

`default_nettype wire

[rtl/core/lph_ctrl.sv]
// Controller state machine for the hash table.
// Depends on lph_pkg for the state, command and status types.
`default_nettype none

module lph_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire lph_pkg::sts_t sts,
  output lph_pkg::cmd_t      cmd,
  output logic               busy
);
  import lph_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (sts.skip) begin
            state_next = S_UPDATE;
          end else if (TABLE_POW2) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_HOME;
          end
        end
      end
      S_HOME: begin
        if (sts.home_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.clear     = (state == S_CLEAR);
    cmd.load      = (state == S_IDLE) && start;
    cmd.home_step = (state == S_HOME);
    cmd.issue     = (state == S_SCAN) && !(sts.hit || sts.last);
    cmd.finish    = (state == S_UPDATE);
    busy          = (state != S_IDLE);
  end

endmodule

`default_nettype wire

[rtl/core/lph_datapath.sv]
// Datapath for the hash table: key and value memories, home slot unit,
// probe pointer, match and empty tracking, and the result register.
// Depends on lph_pkg for beat types and the command and status bundles.
`default_nettype none

module lph_datapath (
  input  wire                clk,
  input  wire                rst,
  input  wire lph_pkg::req_t request,
  input  wire lph_pkg::cmd_t cmd,
  output lph_pkg::sts_t      sts,
  output lph_pkg::rsp_t      result,
  output logic               done
);
  import lph_pkg::*;

  logic [31:0] key_mem [TABLE_ENTRIES];
  logic [31:0] val_mem [TABLE_ENTRIES];

  // Request held for the whole operation.
  logic [1:0]  req_mode;
  logic [31:0] req_key;
  logic [31:0] req_val;
  logic        req_bad;

  // Home slot by reciprocal multiply: the quotient estimate is low by at
  // most one, so one compare and subtract finishes the remainder.
  logic [1:0]       home_cnt;
  logic [31:0]      home_q;
  logic [31:0]      home_qn;
  logic [31:0]      home_diff;
  logic [IDX_W-1:0] home_slot;

  // Probe state.
  logic [IDX_W-1:0] probe_addr;
  logic [IDX_W-1:0] probe_inc;
  logic [CNT_W-1:0] issued_cnt;
  logic [CNT_W-1:0] checked_cnt;
  logic             do_read;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_key;
  logic [31:0]      rd_val;
  logic             rd_hit;
  logic             rd_empty;

  logic             found;
  logic [IDX_W-1:0] hit_slot;
  logic [31:0]      prev_val;
  logic             have_empty;
  logic [IDX_W-1:0] empty_slot;

  logic [IDX_W-1:0] clr_addr;

  // Write port.
  logic             key_we;
  logic             val_we;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_key;
  logic [31:0]      wr_val;
  rsp_t             rsp_next;

  assign home_diff = req_key - home_qn;
  assign home_slot = (home_diff >= 32'(TABLE_ENTRIES))
                     ? IDX_W'(home_diff - 32'(TABLE_ENTRIES)) : IDX_W'(home_diff);
  assign probe_inc = (probe_addr == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : probe_addr + 1'b1;
  assign do_read   = cmd.issue && (issued_cnt != CNT_W'(TABLE_ENTRIES));
  assign rd_hit    = rd_valid && (rd_key == req_key);
  assign rd_empty  = rd_valid && (rd_key == 32'd0);

  always_comb begin
    sts.clear_last = (clr_addr == IDX_W'(TABLE_ENTRIES - 1));
    sts.skip       = (request.mode == MODE_NOP) || (request.key == 32'd0) ||
                     ((request.mode == MODE_PUT) && (request.value == 32'd0));
    sts.home_last  = (home_cnt == 2'd2);
    sts.hit        = rd_hit;
    sts.last       = rd_valid && (checked_cnt == CNT_W'(TABLE_ENTRIES - 1));
  end

  // Request capture, home slot and probe bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode   <= request.mode;
      req_key    <= request.key;
      req_val    <= request.value;
      req_bad    <= (request.key == 32'd0) ||
                    ((request.mode == MODE_PUT) && (request.value == 32'd0));
      home_cnt   <= '0;
      probe_addr <= request.key[IDX_W-1:0];
      issued_cnt <= '0;
      checked_cnt <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
      prev_val   <= 32'd0;
    end else begin
      if (cmd.home_step) begin
        // Step 0 forms the quotient estimate, step 1 scales it back by the
        // table size, step 2 corrects and loads the probe pointer.
        home_cnt <= home_cnt + 1'b1;
        home_q   <= 32'(({32'd0, req_key} * {32'd0, HOME_RECIP}) >> 32);
        home_qn  <= home_q * 32'(TABLE_ENTRIES);
        if (home_cnt == 2'd2) begin
          probe_addr <= home_slot;
        end
      end
      if (do_read) begin
        probe_addr <= probe_inc;
        issued_cnt <= issued_cnt + 1'b1;
      end
      if (rd_valid) begin
        checked_cnt <= checked_cnt + 1'b1;
      end
      if (rd_hit) begin
        found    <= 1'b1;
        hit_slot <= rd_addr;
        prev_val <= rd_val;
      end
      if (rd_empty && !have_empty) begin
        have_empty <= 1'b1;
        empty_slot <= rd_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      rd_valid <= do_read;
      done     <= cmd.finish;
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_key  <= key_mem[probe_addr];
      rd_val  <= val_mem[probe_addr];
      rd_addr <= probe_addr;
    end
  end

  // Update decision and write port.
  always_comb begin
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_addr  = hit_slot;
    wr_key   = 32'd0;
    wr_val   = 32'd0;
    rsp_next = '{prev_value: 32'd0, found: 1'b0, status: STAT_DONE};
    if (cmd.clear) begin
      key_we  = 1'b1;
      val_we  = 1'b1;
      wr_addr = clr_addr;
    end else if (cmd.finish) begin
      priority if (req_mode == MODE_NOP) begin
        rsp_next.status = STAT_DONE;
      end else if (req_bad) begin
        rsp_next.status = STAT_REJECT;
      end else if (found) begin
        rsp_next.prev_value = prev_val;
        rsp_next.found      = 1'b1;
        if (req_mode == MODE_PUT) begin
          val_we = 1'b1;
          wr_val = req_val;
        end else if (req_mode == MODE_DEL) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end
      end else if (req_mode == MODE_PUT) begin
        if (have_empty) begin
          key_we  = 1'b1;
          val_we  = 1'b1;
          wr_addr = empty_slot;
          wr_key  = req_key;
          wr_val  = req_val;
        end else begin
          rsp_next.status = STAT_FULL;
        end
      end else begin
        rsp_next.status = STAT_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[verif/lph_checker.sv]
// Checker for the linear probing hash table: watches the request and result
// channels, predicts each result from a mirror of the table and compares.
// Depends on lph_pkg for the beat types, mode and status codes.
module lph_checker (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire           busy,
  input  lph_pkg::req_t request,
  input  wire           done,
  input  lph_pkg::rsp_t result,
  output int            errors,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lph_pkg::*;

  logic [31:0] mirror_key [TABLE_ENTRIES];
  logic [31:0] mirror_val [TABLE_ENTRIES];
  rsp_t        answers_due [$];
  rsp_t        want;
  int          miss_count = 0;

  // Applies one request to the mirror table and returns the answer it gives.
  // The key search covers every slot, so a hole left by a delete never hides
  // a key further along the chain.
  function automatic rsp_t table_access(req_t r);
    rsp_t ans;
    int   idx;
    int   hit;
    int   hole;
    ans  = '0;
    hit  = -1;
    hole = -1;
    ans.status = STAT_DONE;
    if (r.mode == MODE_NOP) return ans;
    if (r.key == 0 || (r.mode == MODE_PUT && r.value == 0)) begin
      ans.status = STAT_REJECT;
      return ans;
    end
    idx = int'(r.key % 32'(TABLE_ENTRIES));
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (hit < 0 && mirror_key[idx] == r.key) hit = idx;
      if (hole < 0 && mirror_key[idx] == 0) hole = idx;
      idx = (idx + 1) % TABLE_ENTRIES;
    end
    if (hit >= 0) begin
      ans.prev_value = mirror_val[hit];
      ans.found      = 1'b1;
      if (r.mode == MODE_PUT) begin
        mirror_val[hit] = r.value;
      end else if (r.mode == MODE_DEL) begin
        mirror_key[hit] = '0;
        mirror_val[hit] = '0;
      end
    end else if (r.mode == MODE_PUT) begin
      if (hole >= 0) begin
        mirror_key[hole] = r.key;
        mirror_val[hole] = r.value;
      end else begin
        ans.status = STAT_FULL;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (mirror_key[i]) begin
        mirror_key[i] = '0;
        mirror_val[i] = '0;
      end
      answers_due.delete();
    end else begin
      // A result beat is checked before a request taken at the same edge is
      // predicted; that request cannot answer in the same cycle.
      if (done) begin
        if (answers_due.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("checker: unexpected result prev=%h found=%b status=%0d",
                     result.prev_value, result.found, result.status);
        end else begin
          want = answers_due.pop_front();
          if (result.prev_value !== want.prev_value || result.found !== want.found ||
              result.status !== want.status) begin
            miss_count++;
            if (miss_count <= 10) begin
              $write("checker: mismatch exp prev=%h found=%b status=%0d, ",
                     want.prev_value, want.found, want.status);
              $display("got prev=%h found=%b status=%0d",
                       result.prev_value, result.found, result.status);
            end
          end
        end
      end
      if (start && !busy) answers_due.push_back(table_access(request));
    end
    errors  <= miss_count;
    pending <= answers_due.size();
  end

endmodule

[verif/tb_linear_probe_hash_table.sv]
// Testbench top for the linear probing hash table: drives request beats and
// gives the verdict. Depends on lph_pkg, the block and lph_checker.
module tb_linear_probe_hash_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lph_pkg::*;

  // The slowest request scans the whole table. Around 1100 beats of that
  // plus the longest sender gap stay well inside this limit, so it only
  // trips on a hang.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Quiet time after the last result: long enough for a full-table scan to
  // surface any stray result.
  localparam int SETTLE      = TABLE_ENTRIES + 64;
  localparam int HOT_COUNT   = 40;
  localparam int FILL_COUNT  = 530;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  request = '0;
  logic  busy;
  logic  done;
  rsp_t  result;
  int    errors;
  int    pending;
  int    cycles = 0;

  logic [31:0] hot_keys [HOT_COUNT];
  logic [31:0] filled_keys [$];
  bit          no_idle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linear_probe_hash_table u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  lph_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  // Watchdog. The clearing sweep after reset is tiny next to this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Holds the request channel quiet until every outstanding beat has been
  // answered. The checker's pending count is registered, so reading it at a
  // clock edge gives a settled value.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Sends one request beat and returns at the edge that takes it. When the
  // next beat follows with no gap, start simply stays high.
  task automatic send_req(logic [1:0] m, logic [31:0] k, logic [31:0] v);
    int gap;
    // Flip now and then between random gaps and back-to-back stretches.
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    // Occasionally let the block run completely dry before the next beat.
    if ($urandom_range(0, 63) == 0) drain();
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= '{mode: m, key: k, value: v};
    do @(posedge clk); while (busy);
  endtask

  // One random request. Most keys come from a small hot set whose home
  // slots crowd around the wrap point of the table, so chains collide,
  // wrap past the last slot and get holes punched into them by deletes.
  task automatic random_req();
    int          pick;
    int          sel;
    logic [31:0] k;
    logic [31:0] v;
    logic [1:0]  m;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 19);
    if (sel < 17)
      k = hot_keys[$urandom_range(0, HOT_COUNT - 1)];
    else if (sel < 19 && filled_keys.size() > 0)
      k = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
    else
      k = $urandom;
    v = $urandom;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    if (pick < 40) begin
      m = MODE_PUT;
    end else if (pick < 70) begin
      m = MODE_GET;
    end else if (pick < 90) begin
      m = MODE_DEL;
    end else if (pick < 94) begin
      m = MODE_NOP;
    end else begin
      // Zero key, which every real operation must turn away.
      m = 2'($urandom_range(MODE_PUT, MODE_DEL));
      k = '0;
    end
    send_req(m, k, v);
  endtask

  initial begin
    int          home;
    logic [31:0] k;
    logic [31:0] v;

    // Hot key set: random upper bits over a clustered home slot, with a
    // quarter of the keys homed anywhere.
    foreach (hot_keys[i]) begin
      if ($urandom_range(0, 3) == 0)
        home = $urandom_range(0, TABLE_ENTRIES - 1);
      else
        home = (TABLE_ENTRIES - 6 + $urandom_range(0, 11)) % TABLE_ENTRIES;
      k = ($urandom / TABLE_ENTRIES) * TABLE_ENTRIES + home;
      hot_keys[i] = (k == 0) ? 32'(TABLE_ENTRIES) : k;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats. The block is still clearing its memories here; the
    // first beat simply waits for busy to fall.
    send_req(MODE_GET, 32'h0000_0005, 32'h0000_0000);   // miss on an empty table
    send_req(MODE_PUT, 32'h0000_0000, 32'h0000_0007);   // put with zero key
    send_req(MODE_PUT, 32'h0000_0009, 32'h0000_0000);   // put with zero value
    send_req(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);   // get with zero key
    send_req(MODE_DEL, 32'h0000_0000, 32'h0000_0001);   // delete with zero key
    send_req(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused mode
    send_req(MODE_NOP, 32'h0000_0000, 32'h0000_0000);
    send_req(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // lands in the last slot
    send_req(MODE_PUT, 32'h0000_01FF, 32'h0000_0001);   // same home, wraps to slot 0
    send_req(MODE_PUT, 32'h0000_0200, 32'h8000_0000);   // home 0 taken, goes on to 1
    send_req(MODE_GET, 32'h0000_0200, 32'h0000_0000);
    send_req(MODE_PUT, 32'hFFFF_FFFF, 32'h1234_5678);   // overwrite, old value back
    send_req(MODE_DEL, 32'h0000_01FF, 32'h0000_0000);   // hole at the head of a chain
    send_req(MODE_GET, 32'h0000_0200, 32'h0000_0000);   // still found past the hole
    send_req(MODE_PUT, 32'h0000_0200, 32'h0000_0003);   // overwrite, no duplicate
    send_req(MODE_PUT, 32'h0000_0400, 32'h7FFF_FFFF);   // new key refills the hole
    send_req(MODE_DEL, 32'h0000_01FF, 32'h0000_0000);   // delete of an absent key
    send_req(MODE_GET, 32'h0000_0001, 32'h0000_0000);
    send_req(MODE_DEL, 32'h0000_0200, 32'h0000_0000);
    send_req(MODE_GET, 32'h0000_0400, 32'h0000_0000);
    send_req(MODE_DEL, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // Random traffic on a lightly loaded table.
    repeat (250) random_req();
    drain();

    // Fill the table with distinct keys until puts start to report full.
    for (int n = 0; n < FILL_COUNT; n++) begin
      k = 32'h8000_0000 + n * TABLE_ENTRIES + $urandom_range(0, TABLE_ENTRIES - 1);
      v = $urandom;
      if (v == 0) v = 32'h0000_0001;
      filled_keys.push_back(k);
      send_req(MODE_PUT, k, v);
    end

    // Full table: overwrites must still work, new keys must be refused.
    repeat (40) random_req();

    // Empty much of it again, leaving holes all over the chains.
    repeat (150)
      send_req(MODE_DEL, filled_keys[$urandom_range(0, filled_keys.size() - 1)], $urandom);
    drain();

    repeat (100) random_req();

    // Wait for the last answers, then a quiet stretch for anything stray.
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/core/lph_pkg.sv
rtl/core/lph_ctrl.sv
rtl/core/lph_datapath.sv
rtl/core/linear_probe_hash_table.sv
verif/lph_checker.sv
verif/tb_linear_probe_hash_table.sv
